/* rtl/gtg_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gtg_pkg
// Types, constants and tables shared by the go-to-goal velocity controller.
// ----------------------------------------------------------------------------
package gtg_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int CNT_W = $clog2(CORDIC_STEPS);

  localparam int CW = 28;
  localparam int ZW = 24;
  localparam int DW = 27;
  localparam int EW = 25;
  localparam int PW = 35;
  localparam int AW = 36;
  localparam int UW = 22;
  localparam int QW = 19;
  localparam int RECIP_SH = 27;

  localparam logic signed [ZW-1:0] HALF_PI_Q20 = 24'sd1647099;
  localparam logic signed [EW-1:0] PI_Q20 = 25'sd3294199;
  localparam logic signed [EW-1:0] TWO_PI_Q20 = 25'sd6588398;
  localparam logic signed [EW-1:0] ERR_LIMIT = 25'sd209715;
  localparam logic signed [DW-1:0] DIST_LIMIT = 27'sd52428;
  localparam logic signed [16:0] INV_GAIN = 17'sd39797;
  localparam logic [22:0] RECIP_M = 23'd5368710;
  localparam logic [AW-1:0] DIV_OFF = 36'd262150;
  localparam logic signed [QW-1:0] Q_OFF = 19'sd10486;

  localparam logic [2:0] MODE_TICK = 3'd0;
  localparam logic [2:0] MODE_POSE = 3'd1;
  localparam logic [2:0] MODE_CIRCLE = 3'd2;
  localparam logic [2:0] MODE_TARGET = 3'd3;
  localparam logic [2:0] MODE_STOP = 3'd4;

  localparam logic [1:0] REG_TARGET_X = 2'd0;
  localparam logic [1:0] REG_TARGET_Y = 2'd1;
  localparam logic [1:0] REG_SPEED = 2'd2;

  typedef struct packed {
    logic [2:0]         mode;
    logic signed [15:0] pose_x;
    logic signed [15:0] pose_y;
    logic signed [15:0] pose_theta;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] linear_vel;
    logic signed [15:0] angular_vel;
    logic               reached;
  } out_item_t;

  typedef enum logic [1:0] {
    RUN_IDLE,
    RUN_CIRCLE,
    RUN_TARGET
  } run_mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CORDIC,
    ST_DIST,
    ST_MUL,
    ST_SCALE,
    ST_RECIP,
    ST_DONE
  } ctl_state_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_POSE,
    OP_START,
    OP_ITER,
    OP_DIST,
    OP_MUL,
    OP_CIRCLE,
    OP_SCALE,
    OP_RECIP,
    OP_OUT,
    OP_STOP
  } dp_op_e;

  typedef enum logic [1:0] {
    BR_TURN,
    BR_DRIVE,
    BR_REACH,
    BR_CIRCLE
  } branch_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic zero_vec;
    logic last_iter;
    logic reach;
  } dp_stat_t;

  function automatic logic signed [ZW-1:0] atan_q20(input logic [4:0] idx);
    logic signed [ZW-1:0] v;
    case (idx)
      5'd0:  v = 24'sd823550;
      5'd1:  v = 24'sd486170;
      5'd2:  v = 24'sd256879;
      5'd3:  v = 24'sd130396;
      5'd4:  v = 24'sd65451;
      5'd5:  v = 24'sd32757;
      5'd6:  v = 24'sd16383;
      5'd7:  v = 24'sd8192;
      5'd8:  v = 24'sd4096;
      5'd9:  v = 24'sd2048;
      5'd10: v = 24'sd1024;
      5'd11: v = 24'sd512;
      5'd12: v = 24'sd256;
      5'd13: v = 24'sd128;
      5'd14: v = 24'sd64;
      5'd15: v = 24'sd32;
      5'd16: v = 24'sd16;
      5'd17: v = 24'sd8;
      5'd18: v = 24'sd4;
      5'd19: v = 24'sd2;
      5'd20: v = 24'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

/* rtl/gtg_datapath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gtg_datapath
// Pose and settings registers, iterative vectoring CORDIC, error and
// distance arithmetic, scaling with rounding division and output register.
// ----------------------------------------------------------------------------
module gtg_datapath
  import gtg_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [1:0] cfg_index_i,
  input  wire logic [6:0] cfg_data_i,
  input  wire in_item_t   in_item_i,
  input  wire dp_cmd_t    cmd_i,
  output dp_stat_t        stat_o,
  output out_item_t       out_item_o
);

  logic [3:0] tgt_x_q, tgt_y_q;
  logic [6:0] spd_q;
  logic signed [15:0] cur_x_q, cur_y_q, cur_hd_q;

  logic signed [CW-1:0] x_q, x_d, y_q, y_d;
  logic signed [ZW-1:0] z_q, z_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic signed [DW-1:0] d_q, d_d;
  logic signed [EW-1:0] err_q, err_d;
  logic signed [PW-1:0] prod_q, prod_d;
  branch_e sel_q, sel_d;
  logic [UW-1:0] u_q, u_d;
  logic signed [QW-1:0] q_q, q_d;
  out_item_t out_q, out_d;

  logic signed [17:0] dx, dy;
  logic signed [CW-1:0] x0, y0, xs, ys;
  logic signed [CW+16:0] mag_prod;
  logic signed [EW-1:0] err_raw;
  logic turn, drive;
  logic signed [PW-1:0] mul_a, spd_x;
  logic signed [AW-1:0] prod_x, a_val, a_sh;
  logic [UW+22:0] r_prod;

  function automatic logic signed [15:0] sat16(input logic signed [QW-1:0] v);
    logic signed [15:0] r;
    if (v > QW'(32767)) begin
      r = 16'sh7fff;
    end else if (v < -QW'(32768)) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tgt_x_q  <= '0;
      tgt_y_q  <= '0;
      spd_q    <= 7'd50;
      cur_x_q  <= '0;
      cur_y_q  <= '0;
      cur_hd_q <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_TARGET_X: tgt_x_q <= cfg_data_i[3:0];
          REG_TARGET_Y: tgt_y_q <= cfg_data_i[3:0];
          REG_SPEED:    spd_q   <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.op == OP_POSE) begin
        cur_x_q  <= in_item_i.pose_x;
        cur_y_q  <= in_item_i.pose_y;
        cur_hd_q <= in_item_i.pose_theta;
      end
    end
  end

  assign dx = $signed({3'b000, tgt_x_q, 11'b0}) - $signed({{2{cur_x_q[15]}}, cur_x_q});
  assign dy = $signed({3'b000, tgt_y_q, 11'b0}) - $signed({{2{cur_y_q[15]}}, cur_y_q});
  assign x0 = {{(CW-26){dx[17]}}, dx, 8'b0};
  assign y0 = {{(CW-26){dy[17]}}, dy, 8'b0};
  assign xs = x_q >>> cnt_q;
  assign ys = y_q >>> cnt_q;
  assign mag_prod = x_q * INV_GAIN;
  assign err_raw = {z_q[ZW-1], z_q} - $signed({{2{cur_hd_q[15]}}, cur_hd_q, 7'b0});
  assign turn = (err_q > ERR_LIMIT) || (err_q < -ERR_LIMIT);
  assign drive = d_q > DIST_LIMIT;
  assign spd_x = $signed({{(PW-7){1'b0}}, spd_q});
  assign mul_a = turn ? {{(PW-EW){err_q[EW-1]}}, err_q} : {{(PW-DW){d_q[DW-1]}}, d_q};
  assign prod_x = {{(AW-PW){prod_q[PW-1]}}, prod_q};
  assign r_prod = u_q * RECIP_M;

  always_comb begin
    case (sel_q)
      BR_TURN: begin
        a_val = (prod_x <<< 2) + (prod_x <<< 1) + AW'(204800);
        a_sh  = a_val >>> 14;
      end
      BR_DRIVE: begin
        a_val = (prod_x <<< 1) + AW'(102400);
        a_sh  = a_val >>> 13;
      end
      default: begin
        a_val = (prod_x <<< 1) + AW'(25);
        a_sh  = a_val >>> 1;
      end
    endcase
  end

  always_comb begin
    x_d   = x_q;
    y_d   = y_q;
    z_d   = z_q;
    cnt_d = cnt_q;
    d_d   = d_q;
    err_d = err_q;
    prod_d = prod_q;
    sel_d = sel_q;
    u_d   = u_q;
    q_d   = q_q;
    out_d = out_q;
    case (cmd_i.op)
      OP_START: begin
        cnt_d = '0;
        if (dx == '0 && dy == '0) begin
          x_d = '0;
          y_d = '0;
          z_d = '0;
        end else if (x0 < 0) begin
          if (y0 >= 0) begin
            x_d = y0;
            y_d = -x0;
            z_d = HALF_PI_Q20;
          end else begin
            x_d = -y0;
            y_d = x0;
            z_d = -HALF_PI_Q20;
          end
        end else begin
          x_d = x0;
          y_d = y0;
          z_d = '0;
        end
      end
      OP_ITER: begin
        cnt_d = cnt_q + 1'b1;
        if (y_q > 0) begin
          x_d = x_q + ys;
          y_d = y_q - xs;
          z_d = z_q + atan_q20(5'(cnt_q));
        end else begin
          x_d = x_q - ys;
          y_d = y_q + xs;
          z_d = z_q - atan_q20(5'(cnt_q));
        end
      end
      OP_DIST: begin
        d_d = mag_prod[DW+15:16];
        if (err_raw > PI_Q20) begin
          err_d = err_raw - TWO_PI_Q20;
        end else if (err_raw <= -PI_Q20) begin
          err_d = err_raw + TWO_PI_Q20;
        end else begin
          err_d = err_raw;
        end
      end
      OP_MUL: begin
        prod_d = mul_a * spd_x;
        if (turn) begin
          sel_d = BR_TURN;
        end else if (drive) begin
          sel_d = BR_DRIVE;
        end else begin
          sel_d = BR_REACH;
        end
      end
      OP_CIRCLE: begin
        prod_d = $signed({{(PW-15){1'b0}}, spd_q, 8'b0});
        sel_d  = BR_CIRCLE;
      end
      OP_SCALE: begin
        u_d = UW'(a_sh + $signed(DIV_OFF));
      end
      OP_RECIP: begin
        q_d = $signed({1'b0, r_prod[RECIP_SH+QW-2:RECIP_SH]}) - Q_OFF;
      end
      OP_OUT: begin
        case (sel_q)
          BR_TURN: begin
            out_d.linear_vel  = '0;
            out_d.angular_vel = sat16(q_q);
            out_d.reached     = 1'b0;
          end
          BR_DRIVE: begin
            out_d.linear_vel  = sat16(q_q);
            out_d.angular_vel = '0;
            out_d.reached     = 1'b0;
          end
          BR_CIRCLE: begin
            out_d.linear_vel  = sat16(q_q);
            out_d.angular_vel = sat16(q_q);
            out_d.reached     = 1'b0;
          end
          default: begin
            out_d.linear_vel  = '0;
            out_d.angular_vel = '0;
            out_d.reached     = 1'b1;
          end
        endcase
      end
      OP_STOP: begin
        out_d = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
    cnt_q  <= cnt_d;
    d_q    <= d_d;
    err_q  <= err_d;
    prod_q <= prod_d;
    sel_q  <= sel_d;
    u_q    <= u_d;
    q_q    <= q_d;
    out_q  <= out_d;
  end

  assign stat_o.zero_vec  = (dx == '0) && (dy == '0);
  assign stat_o.last_iter = cnt_q == CNT_W'(CORDIC_STEPS - 1);
  assign stat_o.reach     = !turn && !drive;
  assign out_item_o       = out_q;

endmodule
`default_nettype wire

/* rtl/gtg_controller.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gtg_controller
// Sequencer: decodes events, tracks run mode, steps the datapath and
// handles the input and output handshakes.
// ----------------------------------------------------------------------------
module gtg_controller
  import gtg_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  input  wire logic [2:0] in_mode_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  input  wire dp_stat_t stat_i,
  output dp_cmd_t       cmd_o
);

  ctl_state_e state_q, state_d;
  run_mode_e run_q, run_d;
  logic out_valid_q, out_valid_d;
  logic accept, out_load;

  assign in_stall_o = (state_q != ST_IDLE) || (out_valid_q && out_stall_i);
  assign accept = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && in_mode_i == MODE_TICK) begin
          if (run_q == RUN_CIRCLE) begin
            state_d = ST_SCALE;
          end else if (run_q == RUN_TARGET) begin
            state_d = stat_i.zero_vec ? ST_DIST : ST_CORDIC;
          end
        end
      end
      ST_CORDIC: if (stat_i.last_iter) state_d = ST_DIST;
      ST_DIST:   state_d = ST_MUL;
      ST_MUL:    state_d = stat_i.reach ? ST_DONE : ST_SCALE;
      ST_SCALE:  state_d = ST_RECIP;
      ST_RECIP:  state_d = ST_DONE;
      ST_DONE:   state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.op = OP_NONE;
    run_d    = run_q;
    out_load = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (in_mode_i)
            MODE_POSE:   cmd_o.op = OP_POSE;
            MODE_CIRCLE: run_d = RUN_CIRCLE;
            MODE_TARGET: run_d = RUN_TARGET;
            MODE_STOP: begin
              run_d    = RUN_IDLE;
              cmd_o.op = OP_STOP;
              out_load = 1'b1;
            end
            MODE_TICK: begin
              if (run_q == RUN_CIRCLE) begin
                cmd_o.op = OP_CIRCLE;
              end else if (run_q == RUN_TARGET) begin
                cmd_o.op = OP_START;
              end
            end
            default: ;
          endcase
        end
      end
      ST_CORDIC: cmd_o.op = OP_ITER;
      ST_DIST:   cmd_o.op = OP_DIST;
      ST_MUL: begin
        cmd_o.op = OP_MUL;
        if (stat_i.reach) run_d = RUN_IDLE;
      end
      ST_SCALE: cmd_o.op = OP_SCALE;
      ST_RECIP: cmd_o.op = OP_RECIP;
      ST_DONE: begin
        cmd_o.op = OP_OUT;
        out_load = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (out_load) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      run_q       <= RUN_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      run_q       <= run_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

/* rtl/go_to_goal_velocity_controller_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// go_to_goal_velocity_controller_top
// Drive-command generator for a unicycle robot: circle, go-to-target, stop.
// ----------------------------------------------------------------------------
// Items: target ticks, circle ticks and stops produce a result item; other
// events produce no item. No new event is taken while one is in progress or
// while a held output item is stalled.
// Reset: run mode idle, pose zero, targets zero, speed setting 50.
// ----------------------------------------------------------------------------
module go_to_goal_velocity_controller_top
  import gtg_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [1:0] cfg_index_i,
  input  wire logic [6:0] cfg_data_i,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire in_item_t   in_item_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output out_item_t       out_item_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready_o = 1'b1;

  gtg_controller u_ctl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_mode_i   (in_item_i.mode),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  gtg_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_item_o  (out_item_o)
  );

endmodule
`default_nettype wire

/* sim/tb_go_to_goal_velocity_controller_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tb_go_to_goal_velocity_controller_top
// Drives event items into the controller, predicts the drive commands from a
// behavioral copy of the control law and CORDIC, and checks every result.
// ----------------------------------------------------------------------------
module tb_go_to_goal_velocity_controller_top;
  import gtg_pkg::*;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      cfg_valid_i = 1'b0;
  logic      cfg_ready_o;
  logic [1:0] cfg_index_i = '0;
  logic [6:0] cfg_data_i = '0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_item_t  in_item_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_item_o;

  go_to_goal_velocity_controller_top dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  localparam longint PI_R = 3294199;
  localparam longint HPI_R = 1647099;

  in_item_t  pending_q[$];
  out_item_t cmd_q[$];
  int        fails = 0;
  int        cmd_count = 0;
  bit        idle_enable = 1'b0;
  int        hold_cycles = 0;

  longint    tgt_x = 0, tgt_y = 0, speed = 50;
  run_mode_e mode_st = RUN_IDLE;
  longint    pos_x = 0, pos_y = 0, heading = 0;

  function automatic longint shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint round_div(longint n, longint d);
    longint a, b, q;
    a = 2 * n + d;
    b = 2 * d;
    q = a / b;
    if (a % b != 0 && a < 0) q--;
    return q;
  endfunction

  function automatic logic [15:0] clamp16(longint v);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  function automatic longint arctan(int i);
    longint t[21] = '{823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192,
                      4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1};
    return (i < 21) ? t[i] : 0;
  endfunction

  task automatic predict_command(input in_item_t it);
    out_item_t r;
    longint dx, dy, x, y, z, t, xs, ys, d, err, v;
    bit hit;
    r = '0;
    hit = 1'b0;
    case (it.mode)
      MODE_POSE: begin
        pos_x = it.pose_x;
        pos_y = it.pose_y;
        heading = it.pose_theta;
      end
      MODE_CIRCLE: mode_st = RUN_CIRCLE;
      MODE_TARGET: mode_st = RUN_TARGET;
      MODE_STOP: begin
        mode_st = RUN_IDLE;
        cmd_q.push_back(r);
      end
      MODE_TICK: begin
        if (mode_st == RUN_CIRCLE) begin
          v = round_div(speed * 256, 25);
          r.linear_vel = clamp16(v);
          r.angular_vel = clamp16(v);
          cmd_q.push_back(r);
        end else if (mode_st == RUN_TARGET) begin
          dx = tgt_x * 2048 - pos_x;
          dy = tgt_y * 2048 - pos_y;
          z = 0;
          x = 0;
          if (dx != 0 || dy != 0) begin
            x = dx * 256;
            y = dy * 256;
            if (x < 0) begin
              if (y >= 0) begin
                t = x; x = y; y = -t; z = HPI_R;
              end else begin
                t = x; x = -y; y = t; z = -HPI_R;
              end
            end
            for (int i = 0; i < CORDIC_STEPS; i++) begin
              xs = shr(x, i);
              ys = shr(y, i);
              if (y > 0) begin
                x += ys; y -= xs; z += arctan(i);
              end else begin
                x -= ys; y += xs; z -= arctan(i);
              end
            end
          end
          d = shr(x * 39797, 16);
          err = z - heading * 128;
          if (err > PI_R) err -= 2 * PI_R;
          else if (err <= -PI_R) err += 2 * PI_R;
          if (err > 209715 || err < -209715) begin
            r.angular_vel = clamp16(round_div(err * 3 * speed, 204800));
          end else if (d > 52428) begin
            r.linear_vel = clamp16(round_div(d * speed, 102400));
          end else begin
            mode_st = RUN_IDLE;
            r.reached = 1'b1;
          end
          cmd_q.push_back(r);
        end
      end
      default: ;
    endcase
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [6:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_TARGET_X: tgt_x = val[3:0];
      REG_TARGET_Y: tgt_y = val[3:0];
      default: speed = val;
    endcase
  endtask

  task automatic drain();
    wait (pending_q.size() == 0 && !in_valid_i && cmd_q.size() == 0);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic queue_item(input logic [2:0] m, input logic [15:0] px,
                            input logic [15:0] py, input logic [15:0] pt);
    in_item_t it;
    it.mode = m;
    it.pose_x = px;
    it.pose_y = py;
    it.pose_theta = pt;
    pending_q.push_back(it);
  endtask

  function automatic logic [15:0] near_coord();
    return 16'($signed($urandom_range(0, 24575)) + $signed($urandom_range(0, 600)) - 300);
  endfunction

  // driver
  in_item_t cur_item;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        predict_command(in_item_i);
        if (pending_q.size() > 0 && !(idle_enable && $urandom_range(0, 99) < 12)) begin
          cur_item = pending_q.pop_front();
          in_item_i <= cur_item;
        end else begin
          in_valid_i <= 1'b0;
        end
      end else if (!in_valid_i && pending_q.size() > 0
                   && !(idle_enable && $urandom_range(0, 99) < 12)) begin
        cur_item = pending_q.pop_front();
        in_item_i <= cur_item;
        in_valid_i <= 1'b1;
      end
    end
  end

  // monitor
  out_item_t want;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        cmd_count++;
        if (cmd_q.size() == 0) begin
          fails++;
          $display("%0t: unexpected result %p", $time, out_item_o);
        end else begin
          want = cmd_q.pop_front();
          if (out_item_o.linear_vel !== want.linear_vel) begin
            fails++;
            $display("%0t: linear_vel expected %0d actual %0d", $time,
                     want.linear_vel, out_item_o.linear_vel);
          end
          if (out_item_o.angular_vel !== want.angular_vel) begin
            fails++;
            $display("%0t: angular_vel expected %0d actual %0d", $time,
                     want.angular_vel, out_item_o.angular_vel);
          end
          if (out_item_o.reached !== want.reached) begin
            fails++;
            $display("%0t: reached expected %0b actual %0b", $time,
                     want.reached, out_item_o.reached);
          end
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= idle_enable && ($urandom_range(0, 99) < 12);
      end
    end
  end

  initial begin
    int sel;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, every event, ignored codes, target at the pose
    queue_item(MODE_TICK, 0, 0, 0);
    queue_item(MODE_CIRCLE, 0, 0, 0);
    queue_item(MODE_TICK, 0, 0, 0);
    queue_item(MODE_TARGET, 0, 0, 0);
    queue_item(MODE_TICK, 0, 0, 0);
    queue_item(MODE_POSE, 16'h7FFF, 16'h8000, 16'h7FFF);
    queue_item(MODE_TICK, 0, 0, 0);
    queue_item(MODE_TARGET, 0, 0, 0);
    queue_item(MODE_POSE, 16'h8000, 16'h7FFF, 16'h8000);
    queue_item(MODE_TICK, 0, 0, 0);
    queue_item(MODE_POSE, 16'h8000, 16'h8000, 16'h0000);
    queue_item(MODE_TICK, 0, 0, 0);
    queue_item(3'd5, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    queue_item(3'd6, 0, 0, 0);
    queue_item(3'd7, 16'hFFFF, 0, 0);
    queue_item(MODE_TICK, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    queue_item(MODE_STOP, 0, 0, 0);
    queue_item(MODE_STOP, 0, 0, 0);
    queue_item(MODE_TICK, 0, 0, 0);
    drain();

    write_reg(REG_TARGET_X, 7'd15);
    write_reg(REG_TARGET_Y, 7'd11);
    write_reg(REG_SPEED, 7'd127);
    queue_item(MODE_CIRCLE, 0, 0, 0);
    queue_item(MODE_TICK, 0, 0, 0);
    queue_item(MODE_POSE, 16'h8000, 16'h8000, 16'h6000);
    queue_item(MODE_TARGET, 0, 0, 0);
    queue_item(MODE_TICK, 0, 0, 0);
    drain();
    write_reg(REG_SPEED, 7'd0);
    queue_item(MODE_CIRCLE, 0, 0, 0);
    queue_item(MODE_TICK, 0, 0, 0);
    drain();

    idle_enable = 1'b1;
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_TARGET_X, 7'($urandom_range(0, 15)));
      write_reg(REG_TARGET_Y, 7'($urandom_range(0, 15)));
      write_reg(REG_SPEED, (ph == 1) ? 7'd99 : (ph == 2) ? 7'd1 : 7'($urandom_range(0, 127)));
      if (ph == 3) hold_cycles = 400;
      idle_enable = (ph != 4);
      for (int n = 0; n < 240; n++) begin
        sel = $urandom_range(0, 99);
        if (sel < 30) queue_item(MODE_POSE, near_coord(), near_coord(), 16'($urandom));
        else if (sel < 40) queue_item(MODE_POSE, 16'($urandom), 16'($urandom), 16'($urandom));
        else if (sel < 72) queue_item(MODE_TICK, 16'($urandom), 16'($urandom), 16'($urandom));
        else if (sel < 84) queue_item(MODE_TARGET, 16'($urandom), 0, 0);
        else if (sel < 91) queue_item(MODE_CIRCLE, 0, 16'($urandom), 0);
        else if (sel < 97) queue_item(MODE_STOP, 16'($urandom), 0, 16'($urandom));
        else queue_item(3'($urandom_range(5, 7)), 16'($urandom), 16'($urandom), 0);
      end
      drain();
    end

    if (fails == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  initial begin
    #3000000;
    $display("Verification failed");
    $finish;
  end

endmodule
`default_nettype wire

/* filelist.f */
rtl/gtg_pkg.sv
rtl/gtg_datapath.sv
rtl/gtg_controller.sv
rtl/go_to_goal_velocity_controller_top.sv
sim/tb_go_to_goal_velocity_controller_top.sv
